### rtl/qpm_pkg.sv
// ----------------------------------------------------------------------------
// qpm_pkg
// Shared types, constants and fixed-point helpers for the pose matrix block.
// ----------------------------------------------------------------------------
package qpm_pkg;

  localparam int QUAT_FRAC_BITS = 14;
  localparam int POS_FRAC_BITS  = 16;
  localparam int OUT_FRAC       = 16;
  localparam int ROT_SHIFT      = 2 * QUAT_FRAC_BITS - OUT_FRAC;
  localparam int SW             = 72;

  localparam logic CMD_MODEL = 1'b0;
  localparam logic CMD_VIEW  = 1'b1;

  typedef logic signed [SW-1:0] wide_t;

  typedef struct packed {
    logic               view;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } item_t;

  localparam wide_t S32_MAX = wide_t'(2147483647);
  localparam wide_t S32_MIN = -wide_t'(2147483647) - wide_t'(1);

  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic wide_t round_shr(input wide_t v, input int s);
    wide_t r;
    if (s == 0) begin
      r = v;
    end else begin
      r = (v + (wide_t'(1) <<< (s - 1))) >>> s;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] pos_to_out(input logic signed [31:0] p);
    logic signed [31:0] r;
    if (POS_FRAC_BITS >= OUT_FRAC) begin
      r = sat32(round_shr(wide_t'(p), POS_FRAC_BITS - OUT_FRAC));
    end else begin
      r = sat32(wide_t'(p) <<< (OUT_FRAC - POS_FRAC_BITS));
    end
    return r;
  endfunction

endpackage

### rtl/qpm_front.sv
// ----------------------------------------------------------------------------
// qpm_front
// Accepts pose transactions, decodes the mode and queues them for the back end.
// ----------------------------------------------------------------------------
module qpm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [159:0]         s_axis_tdata,
  input  logic                 s_axis_tuser,
  output logic                 item_valid,
  input  logic                 item_ready,
  output qpm_pkg::item_t       item
);
  import qpm_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      dec;

  always_comb begin
    dec.view = (s_axis_tuser == CMD_VIEW);
    dec.qx   = s_axis_tdata[15:0];
    dec.qy   = s_axis_tdata[31:16];
    dec.qz   = s_axis_tdata[47:32];
    dec.qw   = s_axis_tdata[63:48];
    dec.px   = s_axis_tdata[95:64];
    dec.py   = s_axis_tdata[127:96];
    dec.pz   = s_axis_tdata[159:128];
  end

  assign s_axis_tready = (count != 2'd2);
  assign item_valid    = (count != 2'd0);
  assign item          = q[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_push_only: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count missed a push");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 2'd1)
    else $error("queue count missed a pop");

endmodule

### rtl/qpm_back.sv
// ----------------------------------------------------------------------------
// qpm_back
// Four-stage pipeline: quaternion products, rotation entries, view products,
// translation column and output register.
// ----------------------------------------------------------------------------
module qpm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  qpm_pkg::item_t item,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [383:0]   m_axis_tdata
);
  import qpm_pkg::*;

  logic en;
  logic v1, v2, v3;

  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic               view1;
  logic signed [31:0] p1 [3];

  logic signed [31:0] r2 [9];
  logic signed [31:0] tm2 [3];
  logic signed [31:0] p2 [3];
  logic               view2;

  logic signed [64:0] pr3 [9];
  logic signed [31:0] r3 [9];
  logic signed [31:0] tm3 [3];
  logic               view3;

  wide_t              one;
  wide_t              e [9];
  logic signed [32:0] n2 [3];
  logic signed [31:0] t4 [3];

  assign en         = !m_axis_tvalid || m_axis_tready;
  assign item_ready = en;
  assign one        = wide_t'(1) <<< (2 * QUAT_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v1            <= item_valid;
      v2            <= v1;
      v3            <= v2;
      m_axis_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx    <= item.qx * item.qx;
      yy    <= item.qy * item.qy;
      zz    <= item.qz * item.qz;
      xy    <= item.qx * item.qy;
      xz    <= item.qx * item.qz;
      yz    <= item.qy * item.qz;
      wx    <= item.qw * item.qx;
      wy    <= item.qw * item.qy;
      wz    <= item.qw * item.qz;
      view1 <= item.view;
      p1[0] <= item.px;
      p1[1] <= item.py;
      p1[2] <= item.pz;
    end
  end

  always_comb begin
    e[0] = one - wide_t'(2) * (wide_t'(yy) + wide_t'(zz));
    e[1] = wide_t'(2) * (wide_t'(xy) - wide_t'(wz));
    e[2] = wide_t'(2) * (wide_t'(xz) + wide_t'(wy));
    e[3] = wide_t'(2) * (wide_t'(xy) + wide_t'(wz));
    e[4] = one - wide_t'(2) * (wide_t'(xx) + wide_t'(zz));
    e[5] = wide_t'(2) * (wide_t'(yz) - wide_t'(wx));
    e[6] = wide_t'(2) * (wide_t'(xz) - wide_t'(wy));
    e[7] = wide_t'(2) * (wide_t'(yz) + wide_t'(wx));
    e[8] = one - wide_t'(2) * (wide_t'(xx) + wide_t'(yy));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        r2[i] <= sat32(round_shr(e[i], ROT_SHIFT));
      end
      for (int j = 0; j < 3; j++) begin
        tm2[j] <= pos_to_out(p1[j]);
        p2[j]  <= p1[j];
      end
      view2 <= view1;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n2[j] = -(33'(p2[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr3[i*3+j] <= r2[i*3+j] * n2[j];
        end
      end
      r3    <= r2;
      tm3   <= tm2;
      view3 <= view2;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (view3) begin
        t4[i] = sat32(round_shr(wide_t'(pr3[i*3]) + wide_t'(pr3[i*3+1])
                                + wide_t'(pr3[i*3+2]), POS_FRAC_BITS));
      end else begin
        t4[i] = tm3[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_axis_tdata[i*128 +: 32]      <= r3[i*3];
        m_axis_tdata[i*128 + 32 +: 32] <= r3[i*3+1];
        m_axis_tdata[i*128 + 64 +: 32] <= r3[i*3+2];
        m_axis_tdata[i*128 + 96 +: 32] <= t4[i];
      end
    end
  end

endmodule

### rtl/quaternion_pose_matrix_top.sv
// ----------------------------------------------------------------------------
// quaternion_pose_matrix_top
// Quaternion and position to the top three rows of a model or view matrix.
// ----------------------------------------------------------------------------
// An accepted input passes through the two-entry queue and the four back-end stages to m_axis_tvalid.
// Throughput: one transaction per cycle while m_axis_tready is high; output stalls freeze the back end.
// A two-entry queue between front and back absorbs output stalls.
// Reset: synchronous, clears the queue and all pipeline valid flags.
module quaternion_pose_matrix_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // qx, qy, qz, qw, px, py, pz
  input  logic         s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [383:0] m_axis_tdata   // m00..m03, m10..m13, m20..m23
);
  import qpm_pkg::*;

  logic  item_valid;
  logic  item_ready;
  item_t item;

  qpm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  qpm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### tb/quaternion_pose_matrix_checker.sv
// ----------------------------------------------------------------------------
// quaternion_pose_matrix_checker
// Watches both stream channels of the pose matrix block, predicts the twelve
// matrix entries of every accepted pose and compares each output transaction
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module quaternion_pose_matrix_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [383:0] m_axis_tdata,
  output int           errors,
  output int           pending,
  output int           accepted
);
  timeunit 1ns;
  timeprecision 1ps;
  import qpm_pkg::*;

  typedef logic signed [95:0] acc_t;

  logic [383:0] matrix_q[$];

  function automatic logic signed [31:0] clamp32(input acc_t v);
    if (v > acc_t'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -acc_t'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] rot_entry(input acc_t e);
    acc_t r;
    r = (e + (acc_t'(1) <<< (2 * QUAT_FRAC_BITS - OUT_FRAC - 1)))
        >>> (2 * QUAT_FRAC_BITS - OUT_FRAC);
    return clamp32(r);
  endfunction

  function automatic logic [383:0] pose_matrix(input logic vw, input logic [159:0] d);
    acc_t x, y, z, w, one, s;
    acc_t p[3];
    logic signed [31:0] r[3][3];
    logic signed [31:0] m[12];
    logic [383:0] o;
    x = acc_t'($signed(d[15:0]));
    y = acc_t'($signed(d[31:16]));
    z = acc_t'($signed(d[47:32]));
    w = acc_t'($signed(d[63:48]));
    p[0] = acc_t'($signed(d[95:64]));
    p[1] = acc_t'($signed(d[127:96]));
    p[2] = acc_t'($signed(d[159:128]));
    one = acc_t'(1) <<< (2 * QUAT_FRAC_BITS);
    r[0][0] = rot_entry(one - 2 * (y * y + z * z));
    r[0][1] = rot_entry(2 * (x * y - w * z));
    r[0][2] = rot_entry(2 * (x * z + w * y));
    r[1][0] = rot_entry(2 * (x * y + w * z));
    r[1][1] = rot_entry(one - 2 * (x * x + z * z));
    r[1][2] = rot_entry(2 * (y * z - w * x));
    r[2][0] = rot_entry(2 * (x * z - w * y));
    r[2][1] = rot_entry(2 * (y * z + w * x));
    r[2][2] = rot_entry(one - 2 * (x * x + y * y));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) m[i * 4 + j] = r[i][j];
      if (vw == CMD_VIEW) begin
        s = 0;
        for (int j = 0; j < 3; j++) s = s + acc_t'(r[i][j]) * (-p[j]);
        m[i * 4 + 3] = clamp32((s + (acc_t'(1) <<< (POS_FRAC_BITS - 1)))
                               >>> POS_FRAC_BITS);
      end else if (POS_FRAC_BITS >= OUT_FRAC) begin
        m[i * 4 + 3] = clamp32(POS_FRAC_BITS == OUT_FRAC ? p[i] :
          (p[i] + (acc_t'(1) <<< (POS_FRAC_BITS - OUT_FRAC - 1)))
          >>> (POS_FRAC_BITS - OUT_FRAC));
      end else begin
        m[i * 4 + 3] = clamp32(p[i] <<< (OUT_FRAC - POS_FRAC_BITS));
      end
    end
    for (int k = 0; k < 12; k++) o[k * 32 +: 32] = m[k];
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  assign pending = matrix_q.size();

  always @(posedge clk) begin
    logic [383:0] exp_m;
    if (rst) begin
      matrix_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (matrix_q.size() == 0) begin
          report_mismatch("output transaction with no pose waiting");
        end else begin
          exp_m = matrix_q.pop_front();
          for (int k = 0; k < 12; k++)
            if (m_axis_tdata[k * 32 +: 32] !== exp_m[k * 32 +: 32])
              report_mismatch($sformatf("m%0d%0d got %h want %h", k / 4, k % 4,
                m_axis_tdata[k * 32 +: 32], exp_m[k * 32 +: 32]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        matrix_q.push_back(pose_matrix(s_axis_tuser, s_axis_tdata));
        accepted++;
      end
    end
  end

  initial begin
    errors = 0;
    accepted = 0;
  end
endmodule

### tb/quaternion_pose_matrix_top_test.sv
// ----------------------------------------------------------------------------
// quaternion_pose_matrix_top_test
// Drives directed and random poses into the pose matrix block with random
// idling on both sides, a long output hold-off and a drain pause, and gives
// the verdict from the checker's mismatch count and from a stall watchdog.
// ----------------------------------------------------------------------------
module quaternion_pose_matrix_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qpm_pkg::*;

  localparam int NUM_RANDOM = 1030;
  localparam int STALL_LIMIT = 2000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [383:0] m_axis_tdata;

  int  errors, pending, accepted;
  bit  hold_off;
  bit  quiet;
  bit  done;
  int  idle_cycles;

  quaternion_pose_matrix_top u_dut (.*);

  quaternion_pose_matrix_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] rand_q(input int kind);
    logic [15:0] v;
    case (kind)
      0: v = 16'h4000;
      1: v = 16'hc000;
      2: v = 16'h7fff;
      3: v = 16'h8000;
      4: v = 16'h0000;
      5: v = 16'($signed($urandom_range(0, 32768)) - 16384);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_p();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 2 ** 22)) - 32'(2 ** 21);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pose(input logic vw, input logic [159:0] d);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= vw;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random(input int kind);
    logic [159:0] d;
    d[15:0]    = rand_q(kind);
    d[31:16]   = rand_q(kind == 0 ? 5 : kind);
    d[47:32]   = rand_q(kind == 0 ? 5 : kind);
    d[63:48]   = rand_q(kind == 0 ? 5 : kind);
    d[95:64]   = rand_p();
    d[127:96]  = rand_p();
    d[159:128] = rand_p();
    send_pose(logic'($urandom_range(0, 1)), d);
  endtask

  // receiver idling, with one long hold-off
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        n = 0;
        while (n < 60) begin
          @(posedge clk);
          n++;
        end
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !done) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [15:0] qv[6];
    logic [31:0] pv[4];
    logic [159:0] d;
    qv = '{16'h0000, 16'h4000, 16'hc000, 16'h7fff, 16'h8000, 16'h2d41};
    pv = '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'hffffffff};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_MODEL;
    hold_off = 1'b0;
    quiet = 1'b0;
    done = 1'b0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: identity, extreme and non-unit quaternions
    for (int i = 0; i < 12; i++) begin
      d = '0;
      d[15:0]    = qv[i % 6];
      d[31:16]   = qv[(i + 1) % 6];
      d[47:32]   = qv[(i + 3) % 6];
      d[63:48]   = qv[(i + 4) % 6];
      d[95:64]   = pv[i % 4];
      d[127:96]  = pv[(i + 1) % 4];
      d[159:128] = pv[(i + 2) % 4];
      send_pose(i[0] ? CMD_VIEW : CMD_MODEL, d);
    end
    d = '1;
    send_pose(CMD_VIEW, d);
    d = '0;
    d[63:48] = 16'h4000;
    send_pose(CMD_MODEL, d);
    d = {32'h80000000, 32'h80000000, 32'h80000000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000};
    send_pose(CMD_VIEW, d);
    d = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff};
    send_pose(CMD_VIEW, d);
    // long output hold-off while offering poses back to back
    hold_off = 1'b1;
    quiet = 1'b1;
    for (int i = 0; i < 20; i++) send_random($urandom_range(0, 6));
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;
    // pause until all matrices are out
    do @(posedge clk); while (pending != 0);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - 150) quiet = 1'b1;
      send_random($urandom_range(0, 6));
    end
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    done = 1'b1;
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### sim.f
rtl/qpm_pkg.sv
rtl/qpm_front.sv
rtl/qpm_back.sv
rtl/quaternion_pose_matrix_top.sv
tb/quaternion_pose_matrix_checker.sv
tb/quaternion_pose_matrix_top_test.sv
